### src/qte_pkg.sv
package qte_pkg;

  // Width of the core operands after reduction.
  localparam int CORE_W = 16;
  // Width of the product and sum terms: |term| <= 2^32.
  localparam int TERM_W = 35;
  // Radicand width and number of root steps, one result bit per step.
  localparam int RAD_W = 64;
  localparam int ROOT_STEPS = 32;
  // Root path latency: abs/select, partial products, product sum, root steps.
  localparam int ROOT_LAT = 3 + ROOT_STEPS;
  // Rotator datapath width; covers the CORDIC gain on 2^34 operands.
  localparam int ROT_W = 38;
  localparam int ZACC_W = 32;

  // atan(2^-i), full turn = 2^32
  localparam logic [ZACC_W-1:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  localparam logic [ZACC_W-1:0] HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic signed [TERM_W-1:0] n;
    logic signed [TERM_W-1:0] roll_y;
    logic signed [TERM_W-1:0] roll_x;
    logic signed [TERM_W-1:0] yaw_y;
    logic signed [TERM_W-1:0] yaw_x;
    logic signed [TERM_W-1:0] s;
    logic                     inv;
  } terms_t;

  typedef struct packed {
    logic s_pos;
    logic clamp;
    logic inv;
  } flags_t;

endpackage

### src/qte_in_if.sv
interface qte_in_if #(
  parameter int QUAT_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [QUAT_WIDTH-1:0] quat_w;
  logic signed [QUAT_WIDTH-1:0] quat_x;
  logic signed [QUAT_WIDTH-1:0] quat_y;
  logic signed [QUAT_WIDTH-1:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

### src/qte_out_if.sv
interface qte_out_if #(
  parameter int ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] roll_angle;
  logic signed [ANGLE_WIDTH-1:0] pitch_angle;
  logic signed [ANGLE_WIDTH-1:0] yaw_angle;
  logic                          pitch_clamped;
  logic                          invalid;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  invalid, input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                invalid, output ready);
endinterface

### src/qte_terms.sv
module qte_terms #(
  parameter int QUAT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [QUAT_WIDTH-1:0] qw,
  input  logic signed [QUAT_WIDTH-1:0] qx,
  input  logic signed [QUAT_WIDTH-1:0] qy,
  input  logic signed [QUAT_WIDTH-1:0] qz,
  output logic                         out_valid,
  output qte_pkg::terms_t              terms
);

  localparam int CW = qte_pkg::CORE_W;
  localparam int TW = qte_pkg::TERM_W;

  logic signed [CW-1:0] w_c, x_c, y_c, z_c;
  logic signed [CW-1:0] w_r, x_r, y_r, z_r;
  logic                 v1_r, v2_r, v3_r;
  logic signed [2*CW-1:0] ww_r, xx_r, yy_r, zz_r, wx_r, yz_r, wz_r, xy_r, wy_r, zx_r;
  qte_pkg::terms_t      terms_r, terms_nxt;

  // scale to 16 significant bits: floor on the right shift when wider, left shift when narrower
  generate
    if (QUAT_WIDTH >= CW) begin : g_down
      assign w_c = CW'(qw >>> (QUAT_WIDTH - CW));
      assign x_c = CW'(qx >>> (QUAT_WIDTH - CW));
      assign y_c = CW'(qy >>> (QUAT_WIDTH - CW));
      assign z_c = CW'(qz >>> (QUAT_WIDTH - CW));
    end else begin : g_up
      assign w_c = CW'(qw) <<< (CW - QUAT_WIDTH);
      assign x_c = CW'(qx) <<< (CW - QUAT_WIDTH);
      assign y_c = CW'(qy) <<< (CW - QUAT_WIDTH);
      assign z_c = CW'(qz) <<< (CW - QUAT_WIDTH);
    end
  endgenerate

  always_comb begin
    terms_nxt.n      = TW'(ww_r) + TW'(xx_r) + TW'(yy_r) + TW'(zz_r);
    terms_nxt.roll_y = (TW'(wx_r) + TW'(yz_r)) <<< 1;
    terms_nxt.roll_x = terms_nxt.n - ((TW'(xx_r) + TW'(yy_r)) <<< 1);
    terms_nxt.yaw_y  = (TW'(wz_r) + TW'(xy_r)) <<< 1;
    terms_nxt.yaw_x  = terms_nxt.n - ((TW'(yy_r) + TW'(zz_r)) <<< 1);
    terms_nxt.s      = (TW'(wy_r) - TW'(zx_r)) <<< 1;
    terms_nxt.inv    = (terms_nxt.n == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= w_c;
      x_r <= x_c;
      y_r <= y_c;
      z_r <= z_c;
      ww_r <= w_r * w_r;
      xx_r <= x_r * x_r;
      yy_r <= y_r * y_r;
      zz_r <= z_r * z_r;
      wx_r <= w_r * x_r;
      yz_r <= y_r * z_r;
      wz_r <= w_r * z_r;
      xy_r <= x_r * y_r;
      wy_r <= w_r * y_r;
      zx_r <= z_r * x_r;
      terms_r <= terms_nxt;
    end
  end

  assign out_valid = v3_r;
  assign terms     = terms_r;

endmodule

### src/qte_root.sv
module qte_root (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [qte_pkg::TERM_W-1:0] n,
  input  logic signed [qte_pkg::TERM_W-1:0] s,
  output logic                              out_valid,
  output logic        [qte_pkg::TERM_W-1:0] c
);

  localparam int TW = qte_pkg::TERM_W;
  localparam int RW = qte_pkg::RAD_W;
  localparam int NS = qte_pkg::ROOT_STEPS;
  localparam int OW = 33;   // t and the selected u fit in 33 bits
  localparam int LW = 17;   // low slice of u for the split product

  logic [TW-1:0] as_c, u_c;
  logic [OW-1:0] t_r, up_r;
  logic          big1_r, big2_r, big3_r;
  logic          v1_r, v2_r, v3_r;
  logic [OW+LW-1:0] plo_r;
  logic [OW+OW-LW-1:0] phi_r;
  logic [RW-1:0] p_r;

  logic [RW-1:0] rem_r  [NS];
  logic [RW-1:0] root_r [NS];
  logic          big_r  [NS];
  logic          vs_r   [NS];

  assign as_c = s[TW-1] ? TW'(-s) : TW'(s);
  assign u_c  = TW'(n) + as_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage: t, u and the radicand scale
      t_r    <= OW'(TW'(n) - as_c);
      big1_r <= (u_c[TW-1:32] != '0);
      up_r   <= (u_c[TW-1:32] != '0) ? OW'(u_c >> 2) : OW'(u_c);
      // stage: split product
      plo_r  <= t_r * up_r[LW-1:0];
      phi_r  <= t_r * up_r[OW-1:LW];
      big2_r <= big1_r;
      // stage: recombine
      p_r    <= RW'(plo_r) + (RW'(phi_r) << LW);
      big3_r <= big2_r;
    end
  end

  // one result bit per step
  generate
    for (genvar k = 0; k < NS; k++) begin : g_step
      localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * k);
      logic [RW-1:0] rem_in, root_in;
      logic          big_in, v_in;
      logic [RW:0]   trial;
      if (k == 0) begin : g_first
        assign rem_in  = p_r;
        assign root_in = '0;
        assign big_in  = big3_r;
        assign v_in    = v3_r;
      end else begin : g_next
        assign rem_in  = rem_r[k-1];
        assign root_in = root_r[k-1];
        assign big_in  = big_r[k-1];
        assign v_in    = vs_r[k-1];
      end
      assign trial = {1'b0, root_in} + {1'b0, BIT};
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vs_r[k] <= 1'b0;
        end else if (en) begin
          vs_r[k] <= v_in;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          big_r[k] <= big_in;
          if ({1'b0, rem_in} >= trial) begin
            rem_r[k]  <= rem_in - RW'(trial);
            root_r[k] <= (root_in >> 1) + BIT;
          end else begin
            rem_r[k]  <= rem_in;
            root_r[k] <= root_in >> 1;
          end
        end
      end
    end
  endgenerate

  assign c = big_r[NS-1] ? TW'({root_r[NS-1][31:0], 1'b0}) : TW'(root_r[NS-1][31:0]);
  assign out_valid = vs_r[NS-1];

endmodule

### src/qte_cordic.sv
module qte_cordic #(
  parameter int STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [qte_pkg::TERM_W-1:0] y,
  input  logic signed [qte_pkg::TERM_W-1:0] x,
  output logic                              out_valid,
  output logic        [qte_pkg::ZACC_W-1:0] z
);

  localparam int RW = qte_pkg::ROT_W;
  localparam int ZW = qte_pkg::ZACC_W;

  logic signed [RW-1:0] x_r [STAGES+1];
  logic signed [RW-1:0] y_r [STAGES+1];
  logic        [ZW-1:0] z_r [STAGES+1];
  logic                 zero_r [STAGES+1];
  logic                 v_r [STAGES+1];

  logic signed [RW-1:0] xe, ye;
  assign xe = RW'(x);
  assign ye = RW'(y);

  // pre-rotation by pi into the right half plane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x == '0) && (y == '0);
      if (x < 0) begin
        x_r[0] <= -xe;
        y_r[0] <= -ye;
        z_r[0] <= qte_pkg::HALF_TURN;
      end else begin
        x_r[0] <= xe;
        y_r[0] <= ye;
        z_r[0] <= '0;
      end
    end
  end

  generate
    for (genvar i = 0; i < STAGES; i++) begin : g_rot
      logic signed [RW-1:0] xs, ys;
      assign xs = x_r[i] >>> i;
      assign ys = y_r[i] >>> i;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i+1] <= 1'b0;
        end else if (en) begin
          v_r[i+1] <= v_r[i];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          zero_r[i+1] <= zero_r[i];
          if (!y_r[i][RW-1]) begin
            x_r[i+1] <= x_r[i] + ys;
            y_r[i+1] <= y_r[i] - xs;
            z_r[i+1] <= z_r[i] + qte_pkg::ATAN_TAB[i];
          end else begin
            x_r[i+1] <= x_r[i] - ys;
            y_r[i+1] <= y_r[i] + xs;
            z_r[i+1] <= z_r[i] - qte_pkg::ATAN_TAB[i];
          end
        end
      end
    end
  endgenerate

  assign z         = zero_r[STAGES] ? '0 : z_r[STAGES];
  assign out_valid = v_r[STAGES];

endmodule

### src/quaternion_to_euler_angles.sv
// Pipeline from input accept to result valid: term products, root of
//   (n-|s|)(n+|s|), CORDIC, rounding.
// Throughput: one item per cycle; the whole pipeline advances together and
//   holds while a result waits in the output register.
// Reset: synchronous active-low rst_n clears every valid bit; data is not reset.
module quaternion_to_euler_angles #(
  parameter int QUAT_WIDTH    = 16,
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst_n,
  qte_in_if.sink    in_ch,
  qte_out_if.source out_ch
);

  localparam int TW  = qte_pkg::TERM_W;
  localparam int ZW  = qte_pkg::ZACC_W;
  localparam int AW  = ANGLE_WIDTH;
  localparam int RL  = qte_pkg::ROOT_LAT;
  localparam int FL  = CORDIC_STAGES + 1;
  localparam int SH  = ZW - AW;

  // global advance: everything moves unless a result is held at the output
  logic en;
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---- products and sums ----
  logic            terms_v;
  qte_pkg::terms_t terms;

  qte_terms #(.QUAT_WIDTH(QUAT_WIDTH)) u_terms (
    .clk, .rst_n, .en,
    .in_valid (in_ch.valid),
    .qw (in_ch.quat_w), .qx (in_ch.quat_x), .qy (in_ch.quat_y), .qz (in_ch.quat_z),
    .out_valid (terms_v),
    .terms     (terms)
  );

  // ---- pitch cosine term: sqrt((n-|s|)(n+|s|)) ----
  logic          root_v;
  logic [TW-1:0] root_c;

  qte_root u_root (
    .clk, .rst_n, .en,
    .in_valid  (terms_v),
    .n         (terms.n),
    .s         (terms.s),
    .out_valid (root_v),
    .c         (root_c)
  );

  // roll/yaw arguments and s ride alongside the root pipeline
  qte_pkg::terms_t side_r [RL];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= terms;
      for (int i = 1; i < RL; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  qte_pkg::terms_t side_d;
  logic [TW-1:0]   abs_s;
  qte_pkg::flags_t flags_in;
  assign side_d         = side_r[RL-1];
  assign abs_s          = side_d.s[TW-1] ? TW'(-side_d.s) : TW'(side_d.s);
  assign flags_in.s_pos = !side_d.s[TW-1];
  assign flags_in.clamp = (abs_s >= TW'(side_d.n));
  assign flags_in.inv   = side_d.inv;

  // ---- three arctangents in parallel ----
  logic          roll_v, pitch_v, yaw_v;
  logic [ZW-1:0] roll_z, pitch_z, yaw_z;

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk, .rst_n, .en, .in_valid (root_v),
    .y (side_d.roll_y), .x (side_d.roll_x),
    .out_valid (roll_v), .z (roll_z)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk, .rst_n, .en, .in_valid (root_v),
    .y (side_d.s), .x ($signed(root_c)),
    .out_valid (pitch_v), .z (pitch_z)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk, .rst_n, .en, .in_valid (root_v),
    .y (side_d.yaw_y), .x (side_d.yaw_x),
    .out_valid (yaw_v), .z (yaw_z)
  );

  qte_pkg::flags_t flag_r [FL];

  always_ff @(posedge clk) begin
    if (en) begin
      flag_r[0] <= flags_in;
      for (int i = 1; i < FL; i++) begin
        flag_r[i] <= flag_r[i-1];
      end
    end
  end

  // ---- round to output width, saturate pitch, apply special cases ----
  logic [AW-1:0] roll_a, pitch_a, yaw_a;

  function automatic logic [AW-1:0] round_angle(input logic [ZW-1:0] zin);
    logic [ZW:0] sum;
    if (SH > 0) begin
      sum = {1'b0, zin} + ((ZW+1)'(1) << (SH > 0 ? SH - 1 : 0));
    end else begin
      sum = {1'b0, zin};
    end
    return sum[SH +: AW];
  endfunction

  localparam logic signed [AW-1:0] QUARTER = AW'(1) <<< (AW - 2);

  logic signed [AW-1:0] pitch_rnd;
  logic signed [AW-1:0] pitch_sat;
  assign roll_a  = round_angle(roll_z);
  assign yaw_a   = round_angle(yaw_z);
  assign pitch_rnd = $signed(round_angle(pitch_z));
  assign pitch_sat = (pitch_rnd > QUARTER) ? QUARTER :
                     (pitch_rnd < -QUARTER) ? -QUARTER : pitch_rnd;

  qte_pkg::flags_t fl;
  assign fl = flag_r[FL-1];

  always_comb begin
    pitch_a = pitch_sat;
    if (fl.clamp) begin
      pitch_a = fl.s_pos ? QUARTER : -QUARTER;
    end
  end

  logic signed [AW-1:0] roll_out_r, pitch_out_r, yaw_out_r;
  logic                 clamp_out_r, inv_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pitch_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fl.inv) begin
        roll_out_r  <= '0;
        pitch_out_r <= '0;
        yaw_out_r   <= '0;
        clamp_out_r <= 1'b0;
      end else begin
        roll_out_r  <= roll_a;
        pitch_out_r <= pitch_a;
        yaw_out_r   <= yaw_a;
        clamp_out_r <= fl.clamp;
      end
      inv_out_r <= fl.inv;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.roll_angle    = roll_out_r;
  assign out_ch.pitch_angle   = pitch_out_r;
  assign out_ch.yaw_angle     = yaw_out_r;
  assign out_ch.pitch_clamped = clamp_out_r;
  assign out_ch.invalid       = inv_out_r;

`ifndef NO_ASSERTIONS
  // the three rotators run in lockstep
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (roll_v == pitch_v) && (yaw_v == pitch_v))
    else $error("rotator valid bits disagree");

  // zero quaternion gives zero angles and no clamp
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && inv_out_r |-> (roll_out_r == '0) && (pitch_out_r == '0) &&
      (yaw_out_r == '0) && !clamp_out_r)
    else $error("invalid item with nonzero result");

  // pitch never leaves the quarter turn
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (pitch_out_r <= QUARTER) && (pitch_out_r >= -QUARTER))
    else $error("pitch out of range");

  // a clamped pitch sits exactly at plus or minus a quarter turn
  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && clamp_out_r |-> (pitch_out_r == QUARTER) || (pitch_out_r == -QUARTER))
    else $error("clamped pitch not at limit");
`endif

endmodule

### bench/tb_quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
module tb_quaternion_to_euler_angles;

  localparam int QW = 16;
  localparam int AW = 16;
  localparam int STAGES = 16;
  // Pipeline depth of the block.
  localparam int PIPE_LAT = 3 + 35 + STAGES + 2;
  localparam int IDLE_LIMIT = 20 * PIPE_LAT + 2000;
  localparam int N_RANDOM = 400;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [AW-1:0] roll;
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] yaw;
    logic                 clamped;
    logic                 inv;
  } euler_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  qte_in_if #(.QUAT_WIDTH(QW)) in_ch ();
  qte_out_if #(.ANGLE_WIDTH(AW)) out_ch ();

  quaternion_to_euler_angles #(
    .QUAT_WIDTH(QW),
    .ANGLE_WIDTH(AW),
    .CORDIC_STAGES(STAGES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Items waiting to be offered, and angles predicted for accepted items.
  quat_t  quat_queue[$];
  euler_t angle_queue[$];

  int  n_errors = 0;
  int  idle_cycles = 0;
  bit  stim_done = 1'b0;
  // Long receiver hold-off, counted by its own process.
  bit  sink_hold = 1'b0;
  // Sender pause until the pipeline drains.
  bit  src_pause = 1'b0;
  // No-idle stretch on both sides.
  bit  no_idle = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint floor_shr(longint v, int k);
    floor_shr = v >>> k;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC, full turn = 2^32.
  function automatic logic [31:0] cordic_angle(longint yv, longint xv);
    logic [31:0] acc;
    longint nx;
    longint ny;
    acc = '0;
    if (xv == 0 && yv == 0) return '0;
    if (xv < 0) begin
      xv = -xv;
      yv = -yv;
      acc = qte_pkg::HALF_TURN;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      if (yv >= 0) begin
        nx = xv + floor_shr(yv, i);
        ny = yv - floor_shr(xv, i);
        acc += qte_pkg::ATAN_TAB[i];
      end else begin
        nx = xv - floor_shr(yv, i);
        ny = yv + floor_shr(xv, i);
        acc -= qte_pkg::ATAN_TAB[i];
      end
      xv = nx;
      yv = ny;
    end
    return acc;
  endfunction

  // Round the 32-bit turn count to AW bits, wrapping.
  function automatic logic [AW-1:0] round_angle(logic [31:0] acc);
    logic [32:0] t;
    t = {1'b0, acc} + (33'd1 << (32 - AW - 1));
    return t[31 -: AW];
  endfunction

  function automatic euler_t predict_euler(quat_t q);
    euler_t e;
    longint w, x, y, z, n, s, as_;
    longint unsigned t, u, c;
    logic signed [AW-1:0] p;
    logic signed [AW-1:0] quarter;
    quarter = AW'(1) << (AW - 2);
    w = q.w; x = q.x; y = q.y; z = q.z;
    n = w * w + x * x + y * y + z * z;
    e = '0;
    if (n == 0) begin
      e.inv = 1'b1;
      return e;
    end
    e.roll = round_angle(cordic_angle(2 * (w * x + y * z), n - 2 * (x * x + y * y)));
    e.yaw = round_angle(cordic_angle(2 * (w * z + x * y), n - 2 * (y * y + z * z)));
    s = 2 * (w * y - z * x);
    as_ = s < 0 ? -s : s;
    if (as_ >= n) begin
      e.pitch = s > 0 ? quarter : -quarter;
      e.clamped = 1'b1;
    end else begin
      t = n - as_;
      u = n + as_;
      if (u < (64'd1 << 32)) c = int_sqrt(t * u);
      else c = 2 * int_sqrt(t * (u >> 2));
      p = round_angle(cordic_angle(s, longint'(c)));
      // saturate beyond a quarter turn
      if (p > quarter) p = quarter;
      if (p < -quarter) p = -quarter;
      e.pitch = p;
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, idling at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      // Accepted item: predict its angles.
      if (in_ch.valid && in_ch.ready) begin
        angle_queue.push_back(predict_euler(
          {in_ch.quat_w, in_ch.quat_x, in_ch.quat_y, in_ch.quat_z}));
        void'(quat_queue.pop_front());
      end
      // Present the head item, or idle. Valid held until accepted.
      if (in_ch.valid && !in_ch.ready) begin
        // keep offering the same item
      end else if (quat_queue.size() != 0 && !src_pause &&
                   (no_idle || $urandom_range(99) >= 22)) begin
        in_ch.valid <= 1'b1;
        in_ch.quat_w <= quat_queue[0].w;
        in_ch.quat_x <= quat_queue[0].x;
        in_ch.quat_y <= quat_queue[0].y;
        in_ch.quat_z <= quat_queue[0].z;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    euler_t exp_e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (angle_queue.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          exp_e = angle_queue.pop_front();
          if (out_ch.roll_angle !== exp_e.roll)
            report_mismatch("roll", out_ch.roll_angle, exp_e.roll);
          if (out_ch.pitch_angle !== exp_e.pitch)
            report_mismatch("pitch", out_ch.pitch_angle, exp_e.pitch);
          if (out_ch.yaw_angle !== exp_e.yaw)
            report_mismatch("yaw", out_ch.yaw_angle, exp_e.yaw);
          if (out_ch.pitch_clamped !== exp_e.clamped)
            report_mismatch("clamp", out_ch.pitch_clamped, exp_e.clamped);
          if (out_ch.invalid !== exp_e.inv)
            report_mismatch("invalid", out_ch.invalid, exp_e.inv);
        end
      end
      out_ch.ready <= !sink_hold && (no_idle || $urandom_range(99) >= 22);
    end
  end

  // Watchdog: cycles with nothing accepted on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver hold-off: long enough that the pipeline fills and stalls input.
  initial begin
    wait (stim_done == 1'b0 && rst_n);
    repeat (150) @(posedge clk);
    sink_hold = 1'b1;
    repeat (4 * PIPE_LAT) @(posedge clk);
    sink_hold = 1'b0;
  end

  function automatic logic signed [QW-1:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return $signed(16'($urandom_range(65535))) >>> $urandom_range(12);
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic quat_t make_quat(int w, int x, int y, int z);
    quat_t q;
    q.w = QW'(w); q.x = QW'(x); q.y = QW'(y); q.z = QW'(z);
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    quat_t q;
    in_ch.valid = 1'b0;
    in_ch.quat_w = '0;
    in_ch.quat_x = '0;
    in_ch.quat_y = '0;
    in_ch.quat_z = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero quaternion, identity, extremes, gimbal lock both ways,
    // half-turn rolls/yaws, pitch at the clamp edge.
    quat_queue.push_back(make_quat(0, 0, 0, 0));
    quat_queue.push_back(make_quat(32767, 0, 0, 0));
    quat_queue.push_back(make_quat(-32768, 0, 0, 0));
    quat_queue.push_back(make_quat(0, 32767, 0, 0));
    quat_queue.push_back(make_quat(0, 0, 32767, 0));
    quat_queue.push_back(make_quat(0, 0, 0, 32767));
    quat_queue.push_back(make_quat(0, -32768, 0, 0));
    quat_queue.push_back(make_quat(0, 0, -32768, 0));
    quat_queue.push_back(make_quat(0, 0, 0, -32768));
    quat_queue.push_back(make_quat(23170, 0, 23170, 0));
    quat_queue.push_back(make_quat(23170, 0, -23170, 0));
    quat_queue.push_back(make_quat(16384, 16384, 16384, 16384));
    quat_queue.push_back(make_quat(16384, -16384, 16384, -16384));
    quat_queue.push_back(make_quat(-32768, -32768, -32768, -32768));
    quat_queue.push_back(make_quat(32767, 32767, 32767, 32767));
    quat_queue.push_back(make_quat(-32768, 32767, -32768, 32767));
    quat_queue.push_back(make_quat(1, 0, 0, 0));
    quat_queue.push_back(make_quat(0, 0, 0, -1));
    quat_queue.push_back(make_quat(23170, 23170, 0, 0));
    quat_queue.push_back(make_quat(23170, 0, 0, -23170));
    quat_queue.push_back(make_quat(23171, 1, 23170, 0));
    quat_queue.push_back(make_quat(-1, -1, -1, -1));

    for (int i = 0; i < N_RANDOM; i++) begin
      // near gimbal lock now and then
      if ($urandom_range(9) == 0) begin
        q.w = 16'($urandom_range(65535)) >>> 1;
        q.y = ($urandom_range(1) != 0) ? q.w : -q.w;
        q.x = 16'($urandom_range(65535)) >>> 1;
        q.z = ($urandom_range(1) != 0) ? q.x : -q.x;
        q.z = q.z + $signed(4'($urandom_range(15)));
      end else begin
        q = make_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
      quat_queue.push_back(q);
      // Sender pause until every expected result has come.
      if (i == 200) begin
        wait (quat_queue.size() == 0);
        src_pause = 1'b1;
        wait (angle_queue.size() == 0);
        @(posedge clk);
        src_pause = 1'b0;
      end
      if (i == 260) no_idle = 1'b1;
      // keep the no-idle stretch until the queued items have gone out
      if (i == 340) begin
        wait (quat_queue.size() == 0);
        no_idle = 1'b0;
      end
    end

    wait (quat_queue.size() == 0);
    stim_done = 1'b1;
    wait (angle_queue.size() == 0);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (n_errors == 0 && angle_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
